FILE: rtl/fpa_pkg.sv
// Package for the fixed-point ALU: action codes, status codes and widths.
// No dependencies.
package fpa_pkg;
	localparam int FRAC_BITS = 8;
	localparam int W = 32;
	localparam int NW = W + FRAC_BITS;   // divide numerator magnitude width
	localparam int QW = NW;              // quotient width

	typedef enum logic [3:0] {
		ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
		ACT_GT = 4'd4, ACT_LT = 4'd5, ACT_GE = 4'd6, ACT_LE = 4'd7,
		ACT_EQ = 4'd8, ACT_NE = 4'd9, ACT_MIN = 4'd10, ACT_MAX = 4'd11,
		ACT_INC = 4'd12, ACT_DEC = 4'd13, ACT_FROM_INT = 4'd14, ACT_TO_INT = 4'd15
	} action_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [3:0] action;
		logic signed [W-1:0] operand_a;
		logic signed [W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [W-1:0] result_value;
		logic compare_true;
		logic [1:0] status;
	} rsp_t;
endpackage

FILE: rtl/fpa_if.sv
// Valid/ready channel interfaces, one for requests and one for responses, each carrying one payload.
// Depends on fpa_pkg for the payload types.
interface fpa_req_if;
	logic valid;
	logic ready;
	fpa_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface fpa_rsp_if;
	logic valid;
	logic ready;
	fpa_pkg::rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/fpa_divider.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage,
// with a stalling enable. Depends on fpa_pkg.
module fpa_divider (
	input  logic clk,
	input  logic en,
	input  logic [fpa_pkg::NW-1:0] num,
	input  logic [fpa_pkg::W-1:0] den,
	output logic [fpa_pkg::QW-1:0] quo,
	output logic round_up
);
	localparam int N = fpa_pkg::NW;
	localparam int DW = fpa_pkg::W + 1;

	logic [N-1:0] num_s [N+1];
	logic [DW-1:0] rem_s [N+1];
	logic [fpa_pkg::W-1:0] den_s [N+1];

	always_comb begin
		num_s[0] = num;
		rem_s[0] = '0;
		den_s[0] = den;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [DW:0] trial;
		logic [DW-1:0] shifted;
		always_comb begin
			shifted = {rem_s[i][DW-2:0], num_s[i][N-1]};
			trial = {1'b0, shifted} - {2'b0, den_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				if (!trial[DW]) begin
					rem_s[i+1] <= trial[DW-1:0];
					num_s[i+1] <= {num_s[i][N-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= shifted;
					num_s[i+1] <= {num_s[i][N-2:0], 1'b0};
				end
			end
		end
	end

	// Quotient bits have shifted fully into the numerator register.
	assign quo = num_s[N];
	assign round_up = ({rem_s[N], 1'b0} >= {1'b0, den_s[N]});
endmodule

FILE: rtl/fixed_point_alu.sv
// Top level of the signed fixed-point ALU, a pipeline with a divider lane.
// Depends on fpa_pkg, fpa_if and fpa_divider.
//
// One item enters per cycle while the output is not stalled, and every
// action takes the same latency from the accepting edge to the result
// on the output. The divider lane sets this latency because it resolves
// one quotient bit per stage. All actions ride the same pipeline,
// so results leave in order. The whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage in place.
module fixed_point_alu (
	input  logic clk,
	input  logic arst_n,
	fpa_req_if.sink in_ch,
	fpa_rsp_if.source out_ch
);
	localparam int W = fpa_pkg::W;
	localparam int F = fpa_pkg::FRAC_BITS;
	localparam int NW = fpa_pkg::NW;
	localparam int D = NW;   // divider stages
	localparam int T = D - 3;
	localparam int L = T + 1;

	logic adv;
	assign adv = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	// Stage 1: register the request and do the cheap arithmetic.
	typedef struct packed {
		logic [3:0] action;
		logic signed [W:0] sum;
		logic signed [W:0] diff;
		logic cmp_gt;
		logic cmp_lt;
		logic signed [W-1:0] a;
		logic signed [W-1:0] b;
		logic b_zero;
		logic neg_q;
	} s1_t;

	logic v_s1;
	s1_t p_s1;
	logic signed [2*W-1:0] prod_s1;
	logic [NW-1:0] dnum;
	logic [W-1:0] dden;
	logic [W:0] ma;
	logic [W:0] mb;

	always_comb begin
		ma = in_ch.data.operand_a[W-1] ? -{1'b1, in_ch.data.operand_a}
			: {1'b0, in_ch.data.operand_a};
		mb = in_ch.data.operand_b[W-1] ? -{1'b1, in_ch.data.operand_b}
			: {1'b0, in_ch.data.operand_b};
		dnum = {ma[W-1:0], {F{1'b0}}};
		dden = mb[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1.action <= in_ch.data.action;
			p_s1.sum <= {in_ch.data.operand_a[W-1], in_ch.data.operand_a}
				+ {in_ch.data.operand_b[W-1], in_ch.data.operand_b};
			p_s1.diff <= {in_ch.data.operand_a[W-1], in_ch.data.operand_a}
				- {in_ch.data.operand_b[W-1], in_ch.data.operand_b};
			p_s1.cmp_gt <= in_ch.data.operand_a > in_ch.data.operand_b;
			p_s1.cmp_lt <= in_ch.data.operand_a < in_ch.data.operand_b;
			p_s1.a <= in_ch.data.operand_a;
			p_s1.b <= in_ch.data.operand_b;
			p_s1.b_zero <= in_ch.data.operand_b == '0;
			p_s1.neg_q <= in_ch.data.operand_a[W-1] ^ in_ch.data.operand_b[W-1];
			prod_s1 <= in_ch.data.operand_a * in_ch.data.operand_b;
		end
	end

	// Stage 2: finish the non-divide actions into a result.
	logic v_s2;
	s1_t p_s2;
	fpa_pkg::rsp_t r_s2;
	fpa_pkg::rsp_t r_c;
	logic [2*W-1:0] pm;
	logic [2*W-F:0] pq;
	logic signed [W+F:0] fi;
	logic [W-1:0] ti;

	function automatic fpa_pkg::rsp_t sat(input logic signed [W:0] v);
		fpa_pkg::rsp_t r;
		r.compare_true = 1'b0;
		r.status = fpa_pkg::ST_OK;
		r.result_value = v[W-1:0];
		if (v[W] != v[W-1]) begin
			r.status = fpa_pkg::ST_OVF;
			r.result_value = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		return r;
	endfunction

	always_comb begin
		pm = prod_s1[2*W-1] ? -prod_s1 : prod_s1;
		pq = (2*W-F+1)'((pm + (2*W)'(1 << (F-1))) >> F);
		fi = {p_s1.a[W-1], p_s1.a, {F{1'b0}}};
		ti = (p_s1.a[W-1] ? -p_s1.a : p_s1.a) >> F;
		r_c = '0;
		case (fpa_pkg::action_t'(p_s1.action))
			fpa_pkg::ACT_ADD: r_c = sat(p_s1.sum);
			fpa_pkg::ACT_SUB: r_c = sat(p_s1.diff);
			fpa_pkg::ACT_MUL: begin
				if (pq > (2*W-F+1)'({1'b0, {(W-1){1'b1}}}) + (2*W-F+1)'(prod_s1[2*W-1])) begin
					r_c.status = fpa_pkg::ST_OVF;
					r_c.result_value = prod_s1[2*W-1] ? {1'b1, {(W-1){1'b0}}}
						: {1'b0, {(W-1){1'b1}}};
				end else begin
					r_c.result_value = prod_s1[2*W-1] ? -pq[W-1:0] : pq[W-1:0];
				end
			end
			fpa_pkg::ACT_GT: r_c.compare_true = p_s1.cmp_gt;
			fpa_pkg::ACT_LT: r_c.compare_true = p_s1.cmp_lt;
			fpa_pkg::ACT_GE: r_c.compare_true = !p_s1.cmp_lt;
			fpa_pkg::ACT_LE: r_c.compare_true = !p_s1.cmp_gt;
			fpa_pkg::ACT_EQ: r_c.compare_true = !p_s1.cmp_gt && !p_s1.cmp_lt;
			fpa_pkg::ACT_NE: r_c.compare_true = p_s1.cmp_gt || p_s1.cmp_lt;
			fpa_pkg::ACT_MIN: r_c.result_value = p_s1.cmp_lt ? p_s1.a : p_s1.b;
			fpa_pkg::ACT_MAX: r_c.result_value = p_s1.cmp_gt ? p_s1.a : p_s1.b;
			fpa_pkg::ACT_INC: r_c = sat({p_s1.a[W-1], p_s1.a} + (W+1)'(1));
			fpa_pkg::ACT_DEC: r_c = sat({p_s1.a[W-1], p_s1.a} - (W+1)'(1));
			fpa_pkg::ACT_FROM_INT: begin
				if (fi[W+F:W-1] != {(F+2){fi[W+F]}}) begin
					r_c.status = fpa_pkg::ST_OVF;
					r_c.result_value = fi[W+F] ? {1'b1, {(W-1){1'b0}}}
						: {1'b0, {(W-1){1'b1}}};
				end else begin
					r_c.result_value = fi[W-1:0];
				end
			end
			fpa_pkg::ACT_TO_INT: r_c.result_value = p_s1.a[W-1] ? -ti : ti;
			default: r_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2 <= p_s1;
			r_s2 <= r_c;
		end
	end

	// Divider lane starts from the input and runs alongside.
	logic [NW-1:0] quo;
	logic rnd;
	fpa_divider u_div (
		.clk(clk), .en(adv), .num(dnum), .den(dden), .quo(quo), .round_up(rnd)
	);

	// Delay line so the side results meet the quotient.
	logic v_dly_q [L];
	fpa_pkg::rsp_t r_dly_q [L];
	logic div_dly_q [L];
	logic bz_dly_q [L];
	logic neg_dly_q [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) v_dly_q[i] <= 1'b0;
		end else if (adv) begin
			v_dly_q[0] <= v_s2;
			for (int i = 1; i < L; i++) v_dly_q[i] <= v_dly_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_dly_q[0] <= r_s2;
			div_dly_q[0] <= p_s2.action == fpa_pkg::ACT_DIV;
			bz_dly_q[0] <= p_s2.b_zero;
			neg_dly_q[0] <= p_s2.neg_q;
			for (int i = 1; i < L; i++) begin
				r_dly_q[i] <= r_dly_q[i-1];
				div_dly_q[i] <= div_dly_q[i-1];
				bz_dly_q[i] <= bz_dly_q[i-1];
				neg_dly_q[i] <= neg_dly_q[i-1];
			end
		end
	end

	// The divider's last stage loads at the same advancing edge at which
	// the item reaches tap D-3 of the delay line.
	logic [NW:0] qr;
	fpa_pkg::rsp_t r_f;
	always_comb begin
		qr = {1'b0, quo} + (NW+1)'(rnd);
		r_f = r_dly_q[T];
		if (div_dly_q[T]) begin
			r_f = '0;
			if (bz_dly_q[T]) begin
				r_f.status = fpa_pkg::ST_DIV0;
			end else if (qr > (NW+1)'({1'b0, {(W-1){1'b1}}}) + (NW+1)'(neg_dly_q[T])) begin
				r_f.status = fpa_pkg::ST_OVF;
				r_f.result_value = neg_dly_q[T] ? {1'b1, {(W-1){1'b0}}}
					: {1'b0, {(W-1){1'b1}}};
			end else begin
				r_f.result_value = neg_dly_q[T] ? -qr[W-1:0] : qr[W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			out_ch.valid <= v_dly_q[T];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_ch.data <= r_f;
	end
endmodule
